>>> hdl/ohlc_pkg.sv
// Shared types and constants for the one-minute OHLC bar builder.
package ohlc_pkg;

  localparam int NUM_INSTRUMENTS_DFLT = 16;
  localparam int SLOT_W = 4;
  localparam int MAX_SLOTS = 2 ** SLOT_W;
  localparam int FIFO_DEPTH = 2;
  localparam int MIN_W = 6;

  typedef struct packed {
    logic [SLOT_W-1:0] instrument_index;
    logic [11:0] tick_year;
    logic [3:0]  tick_month;
    logic [4:0]  tick_day;
    logic [4:0]  tick_hour;
    logic [5:0]  tick_minute;
    logic [31:0] last_price;
    logic [31:0] cumulative_volume;
  } tick_t;

  typedef struct packed {
    logic [SLOT_W-1:0] bar_instrument;
    logic [11:0] bar_year;
    logic [3:0]  bar_month;
    logic [4:0]  bar_day;
    logic [4:0]  bar_hour;
    logic [5:0]  bar_minute;
    logic [31:0] open_price;
    logic [31:0] high_price;
    logic [31:0] low_price;
    logic [31:0] close_price;
    logic [31:0] bar_volume;
  } bar_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [31:0] stamp;
    logic [31:0] price;
    logic [31:0] vol;
  } op_t;

  // per-slot running bar
  typedef struct packed {
    logic [31:0] open_p;
    logic [31:0] high_p;
    logic [31:0] low_p;
    logic [31:0] close_p;
    logic [31:0] start_vol;
    logic [31:0] end_vol;
    logic [31:0] stamp;
  } entry_t;

endpackage

>>> hdl/ohlc_if.sv
// Valid/ready channel interfaces for ticks and finished bars.
interface ohlc_tick_if;
  import ohlc_pkg::*;
  logic  valid;
  logic  ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ohlc_bar_if;
  import ohlc_pkg::*;
  logic valid;
  logic ready;
  bar_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/ohlc_front.sv
// Front end: registers incoming ticks, drops unknown slots, packs the timestamp.
module ohlc_front #(
  parameter int NUM_INSTRUMENTS = ohlc_pkg::NUM_INSTRUMENTS_DFLT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ohlc_tick_if.sink     tick_i,
  output logic          push_o,
  output ohlc_pkg::op_t op_o,
  input  logic          push_ready_i
);
  import ohlc_pkg::*;

  logic  vld_q, vld_d;
  tick_t tick_q;
  logic  in_range;
  logic  drain;

  assign in_range = int'(tick_q.instrument_index) < NUM_INSTRUMENTS;
  assign drain    = vld_q && (!in_range || push_ready_i);
  assign tick_i.ready = !vld_q || drain;
  assign push_o   = vld_q && in_range;

  assign op_o.slot  = tick_q.instrument_index;
  assign op_o.stamp = {tick_q.tick_year, tick_q.tick_month, tick_q.tick_day,
                       tick_q.tick_hour, tick_q.tick_minute};
  assign op_o.price = tick_q.last_price;
  assign op_o.vol   = tick_q.cumulative_volume;

  always_comb begin
    vld_d = vld_q;
    if (tick_i.valid && tick_i.ready) begin
      vld_d = 1'b1;
    end else if (drain) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      tick_q <= tick_i.data;
    end
  end

endmodule

>>> hdl/ohlc_fifo.sv
// Short queue between front end and bar engine.
module ohlc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ohlc_pkg::op_t op_i,
  output logic          push_ready_o,
  output logic          head_valid_o,
  output ohlc_pkg::op_t head_o,
  input  logic          pop_i
);
  import ohlc_pkg::*;

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(FIFO_DEPTH);

  op_t             buf_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign head_valid_o = cnt_q != '0;
  assign head_o       = buf_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

>>> hdl/ohlc_engine.sv
// Bar engine: per-slot read-modify-write of the running bar, emits closed bars.
module ohlc_engine #(
  parameter int NUM_INSTRUMENTS = ohlc_pkg::NUM_INSTRUMENTS_DFLT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  ohlc_pkg::op_t head_i,
  output logic          pop_o,
  ohlc_bar_if.source    bar_o
);
  import ohlc_pkg::*;

  localparam int Depth = (NUM_INSTRUMENTS < MAX_SLOTS) ? NUM_INSTRUMENTS : MAX_SLOTS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t           mem_q [Depth];
  logic [Depth-1:0] act_q, act_d;

  logic       b_vld_q, b_vld_d;
  op_t        b_q;
  entry_t     rd_q;
  logic       fwd_vld_q;
  logic [AddrW-1:0] fwd_addr_q;
  entry_t     fwd_q;

  logic       out_vld_q, out_vld_d;
  bar_t       out_q;

  logic [AddrW-1:0] b_addr;
  entry_t     cur;
  entry_t     nxt;
  logic       active;
  logic       emit;
  logic       out_free;
  logic       b_done;
  logic       load_b;
  bar_t       bar_d;

  assign b_addr   = b_q.slot[AddrW-1:0];
  assign active   = act_q[b_addr];
  assign cur      = (fwd_vld_q && fwd_addr_q == b_addr) ? fwd_q : rd_q;
  assign emit     = active && (cur.stamp[MIN_W-1:0] != b_q.stamp[MIN_W-1:0]);
  assign out_free = !out_vld_q || bar_o.ready;
  assign b_done   = b_vld_q && (!emit || out_free);
  assign load_b   = head_valid_i && (!b_vld_q || b_done);
  assign pop_o    = load_b;

  always_comb begin
    if (!active || emit) begin
      nxt.open_p    = b_q.price;
      nxt.high_p    = b_q.price;
      nxt.low_p     = b_q.price;
      nxt.start_vol = b_q.vol;
    end else begin
      nxt.open_p    = cur.open_p;
      nxt.high_p    = (b_q.price > cur.high_p) ? b_q.price : cur.high_p;
      nxt.low_p     = (b_q.price < cur.low_p) ? b_q.price : cur.low_p;
      nxt.start_vol = cur.start_vol;
    end
    nxt.close_p = b_q.price;
    nxt.end_vol = b_q.vol;
    nxt.stamp   = b_q.stamp;
  end

  always_comb begin
    bar_d.bar_instrument = b_q.slot;
    bar_d.bar_year       = cur.stamp[31:20];
    bar_d.bar_month      = cur.stamp[19:16];
    bar_d.bar_day        = cur.stamp[15:11];
    bar_d.bar_hour       = cur.stamp[10:6];
    bar_d.bar_minute     = cur.stamp[5:0];
    bar_d.open_price     = cur.open_p;
    bar_d.high_price     = cur.high_p;
    bar_d.low_price      = cur.low_p;
    bar_d.close_price    = cur.close_p;
    bar_d.bar_volume     = (cur.end_vol >= cur.start_vol) ?
                           cur.end_vol - cur.start_vol : '0;
  end

  always_comb begin
    act_d = act_q;
    if (b_done) begin
      act_d[b_addr] = 1'b1;
    end
    b_vld_d = load_b ? 1'b1 : (b_done ? 1'b0 : b_vld_q);
    if (b_done && emit) begin
      out_vld_d = 1'b1;
    end else if (bar_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= '0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      b_vld_q   <= b_vld_d;
      out_vld_q <= out_vld_d;
      if (b_done) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  // bar store, read is registered; same-edge write is covered by forwarding
  always_ff @(posedge clk_i) begin
    if (b_done) begin
      mem_q[b_addr] <= nxt;
      fwd_q         <= nxt;
      fwd_addr_q    <= b_addr;
    end
    if (load_b) begin
      rd_q <= mem_q[head_i.slot[AddrW-1:0]];
      b_q  <= head_i;
    end
    if (b_done && emit) begin
      out_q <= bar_d;
    end
  end

  assign bar_o.valid = out_vld_q;
  assign bar_o.data  = out_q;

endmodule

>>> hdl/tick_to_minute_ohlc_bar_core.sv
// One-minute OHLC bar builder: tick stream in, closed-bar stream out.
// The closing tick passes the front, queue and engine registers before its bar is
// registered on bar_o. One tick per cycle unless bar_o stalls a bar; the per-slot
// store read is registered, the last write forwarded: same-slot ticks can follow.
// Reset clears all bar-active flags; bar contents are unknown until first written.
module tick_to_minute_ohlc_bar_core #(
  parameter int NUM_INSTRUMENTS = ohlc_pkg::NUM_INSTRUMENTS_DFLT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ohlc_tick_if.sink tick_i,
  ohlc_bar_if.source bar_o
);
  import ohlc_pkg::*;

  logic push;
  logic push_ready;
  op_t  op;
  logic head_valid;
  op_t  head;
  logic pop;

  ohlc_front #(
    .NUM_INSTRUMENTS(NUM_INSTRUMENTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_i),
    .push_o      (push),
    .op_o        (op),
    .push_ready_i(push_ready)
  );

  ohlc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .op_i        (op),
    .push_ready_o(push_ready),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  ohlc_engine #(
    .NUM_INSTRUMENTS(NUM_INSTRUMENTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .bar_o       (bar_o)
  );

endmodule
